FILE: sv/assert_macros.svh
// Assertion macros for the D2FA transition engine; empty bodies under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every rising clock edge outside reset.
`define D2FA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define D2FA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define D2FA_ASSERT(lbl, prop, msg)
`define D2FA_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: sv/d2fa_pkg.sv
// Shared types, field widths, defaults and helpers of the D2FA transition engine.
package d2fa_pkg;

    // Port field widths
    localparam int FUNC_W  = 2;
    localparam int STATE_W = 10;
    localparam int FIRST_W = 12;
    localparam int COUNT_W = 9;
    localparam int EIDX_W  = 12;
    localparam int SYM_W   = 8;
    localparam int HOPS_W  = 5;

    // Default sizing
    localparam int NUM_STATES_DEF  = 1024;
    localparam int NUM_ENTRIES_DEF = 4096;
    localparam int SYMBOL_BITS_DEF = 8;
    localparam int MAX_HOPS_DEF    = 16;
    localparam int RAM_WIDTH_DEF   = 18;

    // Compare-subtract steps of the reduction; inputs stay below 2**RED_STEPS
    localparam int RED_STEPS = 12;

    typedef enum logic [FUNC_W-1:0] {
        FN_WR_STATE = 2'd0,
        FN_WR_ENTRY = 2'd1,
        FN_STEP     = 2'd2,
        FN_SET      = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_REC,
        S_SCAN,
        S_DONE
    } fsm_t;

    // v mod m for v < 2**RED_STEPS; mask for a power of two, else restoring subtracts
    function automatic logic [31:0] mod_reduce(input logic [31:0] v, input logic [31:0] m);
        logic [31:0] r;
        logic [31:0] mk;
        r  = v;
        mk = m;
        if ((m & (m - 32'd1)) == 32'd0) begin
            r = v & (m - 32'd1);
        end
        else begin
            for (int k = RED_STEPS - 1; k >= 0; k--) begin
                mk = m << k;
                if (r >= mk) begin
                    r = r - mk;
                end
            end
        end
        return r;
    endfunction

endpackage

FILE: sv/d2fa_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module d2fa_ram #(
    parameter int DEPTH = d2fa_pkg::NUM_ENTRIES_DEF,
    parameter int WIDTH = d2fa_pkg::RAM_WIDTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/d2fa_transition_walk.sv
// Top level of the D2FA transition engine: sequencer around the state and entry RAMs.
// Loads (state record, entry) and set-state transfers are captured, then executed.
// A step reads the record of each visited state, then scans its entries, at most
// MAX_HOPS+1 states; the record read and each entry read are one RAM access a cycle.
// One item is in work at a time; a new one is taken while a finished result waits.
// Reset (rst_n, async low) clears the sequencer, output valid and current state (0);
// the RAMs are not cleared and no clearing pass runs.
`include "assert_macros.svh"

module d2fa_transition_walk #(
    parameter int NUM_STATES  = d2fa_pkg::NUM_STATES_DEF,
    parameter int NUM_ENTRIES = d2fa_pkg::NUM_ENTRIES_DEF,
    parameter int SYMBOL_BITS = d2fa_pkg::SYMBOL_BITS_DEF,
    parameter int MAX_HOPS    = d2fa_pkg::MAX_HOPS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // item channel
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic [d2fa_pkg::FUNC_W-1:0]    func,
    input  logic [d2fa_pkg::STATE_W-1:0]   state_index,
    input  logic [d2fa_pkg::STATE_W-1:0]   default_target,
    input  logic [d2fa_pkg::FIRST_W-1:0]   first_entry,
    input  logic [d2fa_pkg::COUNT_W-1:0]   entry_count,
    input  logic [d2fa_pkg::EIDX_W-1:0]    entry_index,
    input  logic [d2fa_pkg::SYM_W-1:0]     symbol,
    input  logic [d2fa_pkg::STATE_W-1:0]   target_state,
    // result channel
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [d2fa_pkg::STATE_W-1:0]   new_state,
    output logic [d2fa_pkg::HOPS_W-1:0]    default_hops,
    output logic                           no_match_error
);

    // State number, entry address, label, hop counter and record widths
    localparam int SW    = $clog2(NUM_STATES);
    localparam int EW    = $clog2(NUM_ENTRIES);
    localparam int LW    = (SYMBOL_BITS < d2fa_pkg::SYM_W) ? SYMBOL_BITS : d2fa_pkg::SYM_W;
    localparam int HW    = $clog2(MAX_HOPS + 1);
    localparam int CW    = d2fa_pkg::COUNT_W;
    localparam int REC_W = SW + EW + CW;    // {default, first, count}
    localparam int ENT_W = SW + LW;         // {target, label}

    // ------------------------------------------------------------------
    // Captured item (payload, no reset)
    // ------------------------------------------------------------------
    d2fa_pkg::func_t          func_reg;
    logic [d2fa_pkg::STATE_W-1:0] sidx_reg;
    logic [d2fa_pkg::STATE_W-1:0] dflt_in_reg;
    logic [d2fa_pkg::FIRST_W-1:0] first_in_reg;
    logic [CW-1:0]                count_in_reg;
    logic [d2fa_pkg::EIDX_W-1:0]  eidx_reg;
    logic [LW-1:0]                sym_reg;
    logic [d2fa_pkg::STATE_W-1:0] tgt_in_reg;

    logic item_xfer;
    assign item_xfer = item_valid && !item_stall;

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            func_reg     <= d2fa_pkg::func_t'(func);
            sidx_reg     <= state_index;
            dflt_in_reg  <= default_target;
            first_in_reg <= first_entry;
            count_in_reg <= entry_count;
            eidx_reg     <= entry_index;
            sym_reg      <= symbol[LW-1:0];
            tgt_in_reg   <= target_state;
        end
    end

    // State numbers and entry addresses wrap to the table sizes
    logic [SW-1:0] sidx_red;
    logic [SW-1:0] dflt_red;
    logic [SW-1:0] tgt_red;
    logic [EW-1:0] first_red;
    logic [EW-1:0] eidx_red;

    assign sidx_red  = SW'(d2fa_pkg::mod_reduce(32'(sidx_reg), 32'(NUM_STATES)));
    assign dflt_red  = SW'(d2fa_pkg::mod_reduce(32'(dflt_in_reg), 32'(NUM_STATES)));
    assign tgt_red   = SW'(d2fa_pkg::mod_reduce(32'(tgt_in_reg), 32'(NUM_STATES)));
    assign first_red = EW'(d2fa_pkg::mod_reduce(32'(first_in_reg), 32'(NUM_ENTRIES)));
    assign eidx_red  = EW'(d2fa_pkg::mod_reduce(32'(eidx_reg), 32'(NUM_ENTRIES)));

    // ------------------------------------------------------------------
    // Memories: state records and labeled entries
    // ------------------------------------------------------------------
    logic             smem_wr_en;
    logic             smem_rd_en;
    logic [SW-1:0]    smem_rd_addr;
    logic [REC_W-1:0] smem_q;
    logic             emem_wr_en;
    logic             emem_rd_en;
    logic [EW-1:0]    emem_rd_addr;
    logic [ENT_W-1:0] emem_q;

    d2fa_ram #(
        .DEPTH (NUM_STATES),
        .WIDTH (REC_W)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (smem_wr_en),
        .wr_addr (sidx_red),
        .wr_data ({dflt_red, first_red, count_in_reg}),
        .rd_en   (smem_rd_en),
        .rd_addr (smem_rd_addr),
        .rd_data (smem_q)
    );

    d2fa_ram #(
        .DEPTH (NUM_ENTRIES),
        .WIDTH (ENT_W)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (emem_wr_en),
        .wr_addr (eidx_red),
        .wr_data ({tgt_red, sym_reg}),
        .rd_en   (emem_rd_en),
        .rd_addr (emem_rd_addr),
        .rd_data (emem_q)
    );

    // Record and entry fields
    logic [SW-1:0] rec_dflt;
    logic [EW-1:0] rec_first;
    logic [CW-1:0] rec_count;
    logic [SW-1:0] ent_tgt;
    logic [LW-1:0] ent_label;

    assign rec_dflt  = smem_q[REC_W-1 -: SW];
    assign rec_first = smem_q[CW +: EW];
    assign rec_count = smem_q[CW-1:0];
    assign ent_tgt   = emem_q[ENT_W-1 -: SW];
    assign ent_label = emem_q[LW-1:0];

    // ------------------------------------------------------------------
    // Walk sequencer
    // ------------------------------------------------------------------
    d2fa_pkg::fsm_t fsm_reg, fsm_next;
    logic [SW-1:0]  cur_reg, cur_next;         // current DFA state
    logic [SW-1:0]  dflt_reg, dflt_next;       // default of the state being scanned
    logic [EW-1:0]  addr_reg, addr_next;       // entry being read
    logic [CW-1:0]  remain_reg, remain_next;   // entries left including addr_reg
    logic [HW-1:0]  hops_reg, hops_next;
    logic [SW-1:0]  res_state_reg, res_state_next;
    logic [HW-1:0]  res_hops_reg, res_hops_next;
    logic           res_err_reg, res_err_next;
    logic                         out_valid_reg, out_valid_next;
    logic [d2fa_pkg::STATE_W-1:0] out_state_reg, out_state_next;
    logic [d2fa_pkg::HOPS_W-1:0]  out_hops_reg, out_hops_next;
    logic                         out_err_reg, out_err_next;

    logic [EW-1:0] addr_inc;
    assign addr_inc = (addr_reg == EW'(NUM_ENTRIES - 1)) ? '0 : EW'(addr_reg + 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= d2fa_pkg::S_IDLE;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dflt_reg      <= dflt_next;
        addr_reg      <= addr_next;
        remain_reg    <= remain_next;
        hops_reg      <= hops_next;
        res_state_reg <= res_state_next;
        res_hops_reg  <= res_hops_next;
        res_err_reg   <= res_err_next;
        out_state_reg <= out_state_next;
        out_hops_reg  <= out_hops_next;
        out_err_reg   <= out_err_next;
    end

    always_comb
    begin
        fsm_next       = fsm_reg;
        cur_next       = cur_reg;
        dflt_next      = dflt_reg;
        addr_next      = addr_reg;
        remain_next    = remain_reg;
        hops_next      = hops_reg;
        res_state_next = res_state_reg;
        res_hops_next  = res_hops_reg;
        res_err_next   = res_err_reg;
        out_state_next = out_state_reg;
        out_hops_next  = out_hops_reg;
        out_err_next   = out_err_reg;
        // a waiting result clears once it transfers
        out_valid_next = out_valid_reg && result_stall;
        smem_wr_en     = 1'b0;
        smem_rd_en     = 1'b0;
        smem_rd_addr   = cur_reg;
        emem_wr_en     = 1'b0;
        emem_rd_en     = 1'b0;
        emem_rd_addr   = addr_reg;

        unique case (fsm_reg)
            d2fa_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    fsm_next = d2fa_pkg::S_EXEC;
                end
            end

            d2fa_pkg::S_EXEC:
            begin
                unique case (func_reg)
                    d2fa_pkg::FN_WR_STATE:
                    begin
                        smem_wr_en = 1'b1;
                        fsm_next   = d2fa_pkg::S_IDLE;
                    end
                    d2fa_pkg::FN_WR_ENTRY:
                    begin
                        emem_wr_en = 1'b1;
                        fsm_next   = d2fa_pkg::S_IDLE;
                    end
                    d2fa_pkg::FN_SET:
                    begin
                        cur_next = sidx_red;
                        fsm_next = d2fa_pkg::S_IDLE;
                    end
                    d2fa_pkg::FN_STEP:
                    begin
                        smem_rd_en   = 1'b1;
                        smem_rd_addr = cur_reg;
                        hops_next    = '0;
                        fsm_next     = d2fa_pkg::S_REC;
                    end
                    default:
                    begin
                        fsm_next = d2fa_pkg::S_IDLE;
                    end
                endcase
            end

            // record of the visited state is on smem_q
            d2fa_pkg::S_REC:
            begin
                dflt_next = rec_dflt;
                if (rec_count != '0)
                begin
                    emem_rd_en   = 1'b1;
                    emem_rd_addr = rec_first;
                    addr_next    = rec_first;
                    remain_next  = rec_count;
                    fsm_next     = d2fa_pkg::S_SCAN;
                end
                else if (hops_reg == HW'(MAX_HOPS))
                begin
                    res_state_next = cur_reg;
                    res_hops_next  = hops_reg;
                    res_err_next   = 1'b1;
                    fsm_next       = d2fa_pkg::S_DONE;
                end
                else
                begin
                    hops_next    = HW'(hops_reg + 1'b1);
                    smem_rd_en   = 1'b1;
                    smem_rd_addr = rec_dflt;
                end
            end

            // entry at addr_reg is on emem_q
            d2fa_pkg::S_SCAN:
            begin
                if (ent_label == sym_reg)
                begin
                    cur_next       = ent_tgt;
                    res_state_next = ent_tgt;
                    res_hops_next  = hops_reg;
                    res_err_next   = 1'b0;
                    fsm_next       = d2fa_pkg::S_DONE;
                end
                else if (remain_reg != CW'(1))
                begin
                    addr_next    = addr_inc;
                    remain_next  = CW'(remain_reg - 1'b1);
                    emem_rd_en   = 1'b1;
                    emem_rd_addr = addr_inc;
                end
                else if (hops_reg == HW'(MAX_HOPS))
                begin
                    res_state_next = cur_reg;
                    res_hops_next  = hops_reg;
                    res_err_next   = 1'b1;
                    fsm_next       = d2fa_pkg::S_DONE;
                end
                else
                begin
                    hops_next    = HW'(hops_reg + 1'b1);
                    smem_rd_en   = 1'b1;
                    smem_rd_addr = dflt_reg;
                    fsm_next     = d2fa_pkg::S_REC;
                end
            end

            // hand the result to the output register once it is free
            d2fa_pkg::S_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next = 1'b1;
                    out_state_next = d2fa_pkg::STATE_W'(res_state_reg);
                    out_hops_next  = d2fa_pkg::HOPS_W'(res_hops_reg);
                    out_err_next   = res_err_reg;
                    fsm_next       = d2fa_pkg::S_IDLE;
                end
            end

            default:
            begin
                fsm_next = d2fa_pkg::S_IDLE;
            end
        endcase
    end

    assign item_stall     = (fsm_reg != d2fa_pkg::S_IDLE);
    assign result_valid   = out_valid_reg;
    assign new_state      = out_state_reg;
    assign default_hops   = out_hops_reg;
    assign no_match_error = out_err_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `D2FA_ASSERT(a_scan_nonempty, (fsm_reg == d2fa_pkg::S_SCAN) |-> (remain_reg != '0), "scan with no entries left")
    `D2FA_ASSERT(a_hops_bound, (fsm_reg == d2fa_pkg::S_REC || fsm_reg == d2fa_pkg::S_SCAN) |-> (hops_reg <= HW'(MAX_HOPS)), "hop count past limit")
    `D2FA_ASSERT(a_err_hops, (out_valid_reg && out_err_reg) |-> (out_hops_reg == d2fa_pkg::HOPS_W'(MAX_HOPS)), "error result without full hop count")
    `D2FA_ASSERT(a_cur_update, !$stable(cur_reg) |-> ($past(fsm_reg) == d2fa_pkg::S_EXEC || $past(fsm_reg) == d2fa_pkg::S_SCAN), "current state changed outside set or match")

endmodule

FILE: tb/d2fa_transition_walk_tb.sv
// Self-checking testbench for the D2FA transition engine: loads, sets and symbol walks.
module d2fa_transition_walk_tb;

    localparam int CMD_GOAL = 1950;   // stimulus stops once this many commands are queued
    localparam int MAX_WAIT = 18;     // longest gap / stall drawn per transfer
    localparam int DRAIN    = 64;     // quiet cycles after the last expected move

    localparam int N_ST  = d2fa_pkg::NUM_STATES_DEF;
    localparam int N_ENT = d2fa_pkg::NUM_ENTRIES_DEF;
    localparam int N_HOP = d2fa_pkg::MAX_HOPS_DEF;

    // One command on the item channel; every field is its own port.
    typedef struct packed {
        d2fa_pkg::func_t                fn;
        logic [d2fa_pkg::STATE_W-1:0]   sidx;
        logic [d2fa_pkg::STATE_W-1:0]   dtgt;
        logic [d2fa_pkg::FIRST_W-1:0]   first;
        logic [d2fa_pkg::COUNT_W-1:0]   cnt;
        logic [d2fa_pkg::EIDX_W-1:0]    eidx;
        logic [d2fa_pkg::SYM_W-1:0]     sym;
        logic [d2fa_pkg::STATE_W-1:0]   tgt;
    } walk_cmd_t;

    // What one step reports.
    typedef struct packed {
        logic [d2fa_pkg::STATE_W-1:0]   state;
        logic [d2fa_pkg::HOPS_W-1:0]    hops;
        logic                           err;
    } move_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                           item_valid = 1'b0;
    logic                           item_stall;
    walk_cmd_t                      item_bus = '0;
    logic                           result_valid;
    logic                           result_stall = 1'b0;
    logic [d2fa_pkg::STATE_W-1:0]   new_state;
    logic [d2fa_pkg::HOPS_W-1:0]    default_hops;
    logic                           no_match_error;

    d2fa_transition_walk dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .func           (item_bus.fn),
        .state_index    (item_bus.sidx),
        .default_target (item_bus.dtgt),
        .first_entry    (item_bus.first),
        .entry_count    (item_bus.cnt),
        .entry_index    (item_bus.eidx),
        .symbol         (item_bus.sym),
        .target_state   (item_bus.tgt),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .new_state      (new_state),
        .default_hops   (default_hops),
        .no_match_error (no_match_error)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Predictor: shadow of the state table, entry table and current state.
    // ------------------------------------------------------------------
    logic [d2fa_pkg::STATE_W-1:0] mdl_default [N_ST];
    logic [d2fa_pkg::FIRST_W-1:0] mdl_first   [N_ST];
    logic [d2fa_pkg::COUNT_W-1:0] mdl_count   [N_ST];
    logic [d2fa_pkg::SYM_W-1:0]   mdl_label   [N_ENT];
    logic [d2fa_pkg::STATE_W-1:0] mdl_target  [N_ENT];
    logic [d2fa_pkg::STATE_W-1:0] mdl_state = '0;

    move_t expected_moves [$];

    // Scan the current state's range; on a miss follow the default pointer.
    // The walk gives up once MAX_HOPS hops have been taken without a match.
    function automatic move_t predict_move(input logic [d2fa_pkg::SYM_W-1:0] sym);
        move_t                        r;
        logic [d2fa_pkg::STATE_W-1:0] st;
        logic [d2fa_pkg::EIDX_W-1:0]  addr;
        bit                           hit;
        bit                           done;
        int                           hops;
        st    = mdl_state;
        hops  = 0;
        hit   = 1'b0;
        done  = 1'b0;
        r.state = mdl_state;
        while (!done)
        begin
            for (int k = 0; k < mdl_count[st] && !hit; k++)
            begin
                // range wraps at the top of the table
                addr = mdl_first[st] + d2fa_pkg::EIDX_W'(k);
                if (mdl_label[addr] == sym)
                begin
                    hit     = 1'b1;
                    r.state = mdl_target[addr];
                end
            end
            if (hit || hops == N_HOP)
                done = 1'b1;
            else
            begin
                st = mdl_default[st];
                hops++;
            end
        end
        r.hops = d2fa_pkg::HOPS_W'(hops);
        r.err  = !hit;
        return r;
    endfunction

    function automatic void absorb_cmd(input walk_cmd_t c);
        move_t r;
        case (c.fn)
            d2fa_pkg::FN_WR_STATE:
            begin
                mdl_default[c.sidx] = c.dtgt;
                mdl_first[c.sidx]   = c.first;
                mdl_count[c.sidx]   = c.cnt;
            end
            d2fa_pkg::FN_WR_ENTRY:
            begin
                mdl_label[c.eidx]  = c.sym;
                mdl_target[c.eidx] = c.tgt;
            end
            d2fa_pkg::FN_SET:
                mdl_state = c.sidx;
            default:
            begin
                r = predict_move(c.sym);
                if (!r.err)
                    mdl_state = r.state;    // on a give-up the walk stays put
                expected_moves.push_back(r);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Command generation. The tables are undefined until written, so the
    // generator keeps one rule: every written state record points (default
    // and range) only at written states and written entries, and every entry
    // targets a written state. Set and step only ever start from such a state,
    // so no walk can touch an unwritten location.
    // ------------------------------------------------------------------
    walk_cmd_t                  queued_cmds [$];
    bit                         rec_live    [N_ST];
    bit                         ent_written [N_ENT];
    logic [d2fa_pkg::SYM_W-1:0] ent_label   [N_ENT];
    int                         live_states [$];
    int                         written_ents[$];
    int                         widest_range = 0;
    longint                     cycle_budget = 0;
    longint                     cycle_limit  = 64'd100_000_000;

    function automatic walk_cmd_t random_cmd();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(walk_cmd_t)-1:0];   // unused fields stay random
    endfunction

    function automatic int pick_live();
        return live_states[$urandom_range(0, live_states.size() - 1)];
    endfunction

    // Labels and symbols lean on a small alphabet so that matches are common.
    function automatic int pick_label();
        return ($urandom_range(0, 9) < 6) ? $urandom_range(0, 7) : $urandom_range(0, 255);
    endfunction

    function automatic int random_state();
        return $urandom_range(0, N_ST - 1);
    endfunction

    function automatic void queue_cmd(input walk_cmd_t c);
        queued_cmds.push_back(c);
        cycle_budget += 2 * MAX_WAIT + 10;
        case (c.fn)
            d2fa_pkg::FN_WR_STATE:
            begin
                if (!rec_live[c.sidx])
                begin
                    rec_live[c.sidx] = 1'b1;
                    live_states.push_back(c.sidx);
                end
                if (c.cnt > widest_range)
                    widest_range = c.cnt;
            end
            d2fa_pkg::FN_WR_ENTRY:
            begin
                if (!ent_written[c.eidx])
                begin
                    ent_written[c.eidx] = 1'b1;
                    written_ents.push_back(c.eidx);
                end
                ent_label[c.eidx] = c.sym;
            end
            d2fa_pkg::FN_STEP:
                cycle_budget += 4 + (N_HOP + 1) * (1 + widest_range);
            default:
                ;
        endcase
    endfunction

    task automatic put_record(input int s, input int dflt, input int first, input int cnt);
        walk_cmd_t c;
        c       = random_cmd();
        c.fn    = d2fa_pkg::FN_WR_STATE;
        c.sidx  = d2fa_pkg::STATE_W'(s);
        c.dtgt  = d2fa_pkg::STATE_W'(dflt);
        c.first = d2fa_pkg::FIRST_W'(first);
        c.cnt   = d2fa_pkg::COUNT_W'(cnt);
        queue_cmd(c);
    endtask

    task automatic put_entry(input int addr, input int sym, input int tgt);
        walk_cmd_t c;
        c      = random_cmd();
        c.fn   = d2fa_pkg::FN_WR_ENTRY;
        c.eidx = d2fa_pkg::EIDX_W'(addr);
        c.sym  = d2fa_pkg::SYM_W'(sym);
        c.tgt  = d2fa_pkg::STATE_W'(tgt);
        queue_cmd(c);
    endtask

    task automatic put_set(input int s);
        walk_cmd_t c;
        c      = random_cmd();
        c.fn   = d2fa_pkg::FN_SET;
        c.sidx = d2fa_pkg::STATE_W'(s);
        queue_cmd(c);
    endtask

    task automatic put_step(input int sym);
        walk_cmd_t c;
        c     = random_cmd();
        c.fn  = d2fa_pkg::FN_STEP;
        c.sym = d2fa_pkg::SYM_W'(sym);
        queue_cmd(c);
    endtask

    task automatic put_steps(input int n, input bit full_range);
        for (int i = 0; i < n; i++)
            put_step(full_range ? $urandom_range(0, 255) : pick_label());
    endtask

    task automatic put_entries(input int start, input int len);
        for (int i = 0; i < len; i++)
            put_entry((start + i) % N_ENT, pick_label(), pick_live());
    endtask

    // Record with a range that lies entirely on written entries (or is empty,
    // in which case first_entry is free).
    task automatic put_rand_record(input int s, input int cap, output int first,
                                   output int cnt);
        int dflt;
        int run;
        dflt  = ($urandom_range(0, 3) == 0) ? s : pick_live();
        first = $urandom_range(0, N_ENT - 1);
        cnt   = 0;
        if (written_ents.size() != 0 && $urandom_range(0, 4) != 0)
        begin
            first = written_ents[$urandom_range(0, written_ents.size() - 1)];
            run   = 0;
            while (run < cap && ent_written[(first + run) % N_ENT])
                run++;
            cnt = $urandom_range(1, run);
        end
        put_record(s, dflt, first, cnt);
    endtask

    // Chain of empty states ending in a state that may have entries; the step from the
    // head matches only at the tail; on a match the hop count equals the chain length.
    // Lengths around MAX_HOPS hit the last allowed hop and the give-up.
    task automatic put_chain();
        int len;
        int link;
        int s;
        int first;
        int cnt;
        len  = ($urandom_range(0, 2) == 0) ? $urandom_range(N_HOP - 1, N_HOP + 1)
                                           : $urandom_range(0, N_HOP + 1);
        link = random_state();
        put_rand_record(link, 8, first, cnt);
        for (int i = 0; i < len; i++)
        begin
            s = random_state();
            put_record(s, link, $urandom_range(0, N_ENT - 1), 0);
            link = s;
        end
        put_set(link);
        put_step((cnt != 0) ? ent_label[first] : pick_label());
    endtask

    // Widest test range: 256 of 260 entries written across the top of the entry table.
    task automatic put_wide_state();
        int start;
        int s;
        start = $urandom_range(N_ENT - 200, N_ENT - 1);
        s     = random_state();
        put_entries(start, 260);
        put_record(s, pick_live(), start, 256);
        put_set(s);
        put_steps(2, 1'b0);
        put_steps(2, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Driver: commands leave the queue one at a time, each after its own gap.
    // Everything changes on the falling edge.
    // ------------------------------------------------------------------
    bit        item_fire   = 1'b0;   // transfer seen at the last rising edge
    bit        res_fire    = 1'b0;
    bit        item_loaded = 1'b0;
    bit        item_quiet  = 1'b0;   // stretches without gaps
    bit        res_quiet   = 1'b0;   // stretches without stalls
    int        item_gap    = 0;
    int        res_hold    = 0;
    walk_cmd_t item_next;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // item side: hold a pending transfer, otherwise move on
            if (!item_valid || item_fire)
            begin
                if (!item_loaded && queued_cmds.size() != 0)
                begin
                    item_next   = queued_cmds.pop_front();
                    item_loaded = 1'b1;
                    if ($urandom_range(0, 63) == 0)
                        item_quiet = !item_quiet;
                    item_gap = item_quiet ? 0 : $urandom_range(0, MAX_WAIT);
                end
                if (item_loaded && item_gap == 0)
                begin
                    item_bus    <= item_next;
                    item_valid  <= 1'b1;
                    item_loaded = 1'b0;
                end
                else
                begin
                    if (item_loaded)
                        item_gap--;
                    item_valid <= 1'b0;
                end
            end

            // result side: a fresh stall length per result
            if (res_fire)
            begin
                if ($urandom_range(0, 63) == 0)
                    res_quiet = !res_quiet;
                res_hold = res_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            end
            else if (result_valid && res_hold != 0)
                res_hold--;
            result_stall <= (res_hold != 0);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted command, check each accepted result.
    // ------------------------------------------------------------------
    int    mismatches = 0;
    move_t want;

    always @(posedge clk)
    begin
        item_fire <= rst_n && item_valid && !item_stall;
        res_fire  <= rst_n && result_valid && !result_stall;
        if (rst_n && item_valid && !item_stall)
            absorb_cmd(item_bus);
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_moves.size() == 0)
            begin
                $display("%0t unexpected move: expected none, actual state %0d hops %0d error %0b",
                         $time, new_state, default_hops, no_match_error);
                mismatches++;
            end
            else
            begin
                want = expected_moves.pop_front();
                if (new_state !== want.state)
                begin
                    $display("%0t new_state: expected %0d, actual %0d",
                             $time, want.state, new_state);
                    mismatches++;
                end
                if (default_hops !== want.hops)
                begin
                    $display("%0t default_hops: expected %0d, actual %0d",
                             $time, want.hops, default_hops);
                    mismatches++;
                end
                if (no_match_error !== want.err)
                begin
                    $display("%0t no_match_error: expected %0b, actual %0b",
                             $time, want.err, no_match_error);
                    mismatches++;
                end
            end
        end
    end

    // Hang guard, sized from the queued stimulus.
    longint cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_limit)
        begin
            $display("d2fa_transition_walk regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial
    begin
        int s;
        int first;
        int cnt;
        int pick;
        int wide_done;
        wide_done = 0;

        // Directed: empty self-looping state gives up after MAX_HOPS hops.
        put_record(0, 0, N_ENT - 1, 0);
        put_step(8'hFF);
        // Top state with a range that wraps from the last entry to the first,
        // holding a repeated label (first in scan order wins).
        put_record(N_ST - 1, 0, 0, 0);
        put_entry(N_ENT - 1, 8'hFF, N_ST - 1);
        put_entry(0, 8'h00, 0);
        put_entry(1, 8'hFF, 0);
        put_record(N_ST - 1, 0, N_ENT - 1, 3);
        put_record(0, N_ST - 1, 0, 0);
        put_step(8'hFF);                  // one hop, match at the wrapped start
        put_step(8'h00);                  // direct match back to state 0
        put_step(8'h55);                  // two-state loop without a match
        put_set(N_ST - 1);
        put_step(8'hFF);
        put_set(0);
        put_step(8'h00);

        // Random: mostly well-formed load / set / walk sequences.
        while (queued_cmds.size() < CMD_GOAL)
        begin
            if (wide_done < 2 && queued_cmds.size() > 300 + 700 * wide_done)
            begin
                put_wide_state();
                wide_done++;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    put_steps($urandom_range(1, 8), 1'b0);
                else if (pick < 45)
                    put_entries($urandom_range(0, N_ENT - 1), $urandom_range(1, 12));
                else if (pick < 65)
                begin
                    s = random_state();
                    put_rand_record(s, 8, first, cnt);
                    if ($urandom_range(0, 1) == 1)
                    begin
                        put_set(s);
                        put_steps($urandom_range(1, 3), 1'b0);
                    end
                end
                else if (pick < 77)
                    put_chain();
                else if (pick < 87)
                    put_set(pick_live());
                else
                    put_steps($urandom_range(1, 3), 1'b1);
            end
        end
        cycle_limit = 3 * cycle_budget + 10_000;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        while (queued_cmds.size() != 0 || item_loaded || item_valid)
            @(posedge clk);
        while (expected_moves.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (mismatches == 0)
            $display("d2fa_transition_walk regression: pass");
        else
            $display("d2fa_transition_walk regression: fail");
        $finish;
    end

endmodule
